>>> rtl/set_assoc_lru_cache_model_unit_assert.svh
// Assertion macros for the set-associative LRU cache model unit.
// Expects signals named clock and reset in the including module.
`ifndef SET_ASSOC_LRU_CACHE_MODEL_UNIT_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define SALC_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define SALC_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SALC_ASSERT_IMP(lbl, ante, cons, msg)

`define SALC_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/salc_pkg.sv
// Shared constants and types for the set-associative LRU cache model unit.
// No dependencies.
package salc_pkg;

   localparam int MAX_SET_BITS = 6;
   localparam int MAX_WAYS     = 8;
   localparam int ADDR_W       = 32;
   localparam int SETS         = 1 << MAX_SET_BITS;
   localparam int SET_IDX_W    = MAX_SET_BITS;
   localparam int WAY_W        = 3;
   localparam int RANK_W       = 3;
   localparam int CNT_W        = 32;

   localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;

   localparam logic [1:0] OP_MODIFY = 2'd2;
   localparam logic [1:0] OP_FETCH  = 2'd3;

   localparam logic [1:0] OUT_HIT     = 2'd0;
   localparam logic [1:0] OUT_FILL    = 2'd1;
   localparam logic [1:0] OUT_EVICT   = 2'd2;
   localparam logic [1:0] OUT_IGNORED = 2'd3;

   localparam logic [1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [1:0] CSR_BLOCK_BITS = 2'd1;
   localparam logic [1:0] CSR_WAYS       = 2'd2;

   localparam logic [2:0] SET_BITS_RST   = 3'd4;
   localparam logic [4:0] BLOCK_BITS_RST = 5'd4;
   localparam logic [3:0] WAYS_RST       = 4'd1;

   typedef struct packed {
      logic [MAX_WAYS-1:0]             valid;
      logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
      logic [MAX_WAYS-1:0][ADDR_W-1:0] tag;
   } row_type;

endpackage

>>> rtl/set_assoc_lru_cache_model_unit.sv
// Set-associative cache hit/miss model with exact per-set LRU ranks.
// Depends on salc_pkg and set_assoc_lru_cache_model_unit_assert.svh.
//
// Usage:
//   req channel: tuser = op (load, store, modify, fetch), tdata = byte address.
//   rsp channel: tuser = outcome [1:0], extra_hit [2];
//                tdata = hit_total, miss_total, eviction_total (32 bits each).
//   csr channel: index 0 set_bits, 1 block_bits, 2 ways; write only while idle.
// Pipeline: an accepted item is held in the lookup stage, and its result is registered for output.
// Throughput: one item per cycle unless the result side stalls. The set row
//   is read from a 64-row line memory at accept; the row written by the item
//   just ahead is forwarded, so back-to-back accesses to one set run at full rate.
// Reset: totals clear, configuration returns to 4/4/1, and per-row valid
//   flags clear at once; rows read as empty until first written. No
//   clearing pass is needed.
// Stall: while rsp_tready is low and a result waits, the item in the lookup
//   stage holds and req_tready drops; nothing is lost or repeated.
`include "set_assoc_lru_cache_model_unit_assert.svh"

module set_assoc_lru_cache_model_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // address [31:0]
   input  logic [1:0]  req_tuser,   // op [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // hit_total [31:0], miss_total [63:32], eviction_total [95:64]
   output logic [2:0]  rsp_tuser,   // outcome [1:0], extra_hit [2]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [4:0]  csr_data
);

   logic [2:0] set_bits_ff;
   logic [4:0] block_bits_ff;
   logic [3:0] ways_ff;

   logic                             s1_valid_ff;
   logic [1:0]                       s1_op_ff;
   logic [salc_pkg::ADDR_W-1:0]      s1_tag_ff;
   logic [salc_pkg::SET_IDX_W-1:0]   s1_set_ff;

   salc_pkg::row_type line_mem_ff [salc_pkg::SETS];
   salc_pkg::row_type mem_q_ff;
   salc_pkg::row_type fwd_row_ff;
   logic              fwd_ff;
   logic [salc_pkg::SETS-1:0] row_init_ff;

   logic                       rsp_valid_ff;
   logic [1:0]                 rsp_outcome_ff;
   logic                       rsp_extra_ff;
   logic [salc_pkg::CNT_W-1:0] hit_ff;
   logic [salc_pkg::CNT_W-1:0] miss_ff;
   logic [salc_pkg::CNT_W-1:0] evict_ff;

   logic                           advance;
   logic                           take;
   logic                           mem_wr;
   logic [2:0]                     sb_eff;
   logic [5:0]                     shift;
   logic [salc_pkg::ADDR_W-1:0]    set_full;
   logic [salc_pkg::SET_IDX_W-1:0] set_mask;
   logic [salc_pkg::SET_IDX_W-1:0] set_in;
   logic [salc_pkg::ADDR_W-1:0]    tag_in;

   logic [3:0]                    nw;
   logic [salc_pkg::MAX_WAYS-1:0] use_vec;
   salc_pkg::row_type             row_cur;
   salc_pkg::row_type             row_in;
   logic [salc_pkg::MAX_WAYS-1:0] hit_vec;
   logic [salc_pkg::MAX_WAYS-1:0] free_vec;
   logic [salc_pkg::MAX_WAYS-1:0] hit_sel;
   logic [salc_pkg::MAX_WAYS-1:0] free_sel;
   logic [salc_pkg::MAX_WAYS-1:0] is_max;
   logic [salc_pkg::MAX_WAYS-1:0] way_sel;
   logic                          any_hit;
   logic                          any_free;
   logic [salc_pkg::WAY_W-1:0]    way;
   logic [salc_pkg::RANK_W-1:0]   way_rank;
   logic [1:0]                    outcome_in;
   logic                          extra_in;
   logic [salc_pkg::CNT_W-1:0]    hit_in;
   logic [salc_pkg::CNT_W-1:0]    miss_in;
   logic [salc_pkg::CNT_W-1:0]    evict_in;

   assign csr_ready  = 1'b1;
   assign advance    = !s1_valid_ff || !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign take       = req_tvalid && advance;
   assign mem_wr     = s1_valid_ff && advance && (s1_op_ff != salc_pkg::OP_FETCH);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_extra_ff, rsp_outcome_ff};
   assign rsp_tdata  = {evict_ff, miss_ff, hit_ff};

   // address split
   always_comb begin
      sb_eff   = (set_bits_ff > 3'(salc_pkg::MAX_SET_BITS)) ?
                 3'(salc_pkg::MAX_SET_BITS) : set_bits_ff;
      shift    = {1'b0, block_bits_ff} + {3'b000, sb_eff};
      tag_in   = (shift >= 6'd32) ? '0 : (req_tdata >> shift);
      set_full = req_tdata >> block_bits_ff;
      set_mask = salc_pkg::SET_IDX_W'((7'd1 << sb_eff) - 7'd1);
      set_in   = set_full[salc_pkg::SET_IDX_W-1:0] & set_mask;
   end

   // lookup and row update
   always_comb begin
      nw = (ways_ff == 4'd0) ? 4'd1 :
           (ways_ff > 4'(salc_pkg::MAX_WAYS)) ? 4'(salc_pkg::MAX_WAYS) : ways_ff;
      row_cur = fwd_ff ? fwd_row_ff : (row_init_ff[s1_set_ff] ? mem_q_ff : '0);
      for (int i = 0; i < salc_pkg::MAX_WAYS; i++) begin
         use_vec[i]  = 4'(i) < nw;
         hit_vec[i]  = use_vec[i] && row_cur.valid[i] && (row_cur.tag[i] == s1_tag_ff);
         free_vec[i] = use_vec[i] && !row_cur.valid[i];
      end
      hit_sel  = hit_vec & (~hit_vec + 1'b1);
      free_sel = free_vec & (~free_vec + 1'b1);
      any_hit  = |hit_vec;
      any_free = |free_vec;
      for (int i = 0; i < salc_pkg::MAX_WAYS; i++) begin
         is_max[i] = use_vec[i];
         for (int j = 0; j < salc_pkg::MAX_WAYS; j++) begin
            if (use_vec[j] && j < i && row_cur.rank[j] >= row_cur.rank[i]) is_max[i] = 1'b0;
            if (use_vec[j] && j > i && row_cur.rank[j] > row_cur.rank[i]) is_max[i] = 1'b0;
         end
      end
      way_sel = any_hit ? hit_sel : (any_free ? free_sel : is_max);
      way = '0;
      for (int i = 0; i < salc_pkg::MAX_WAYS; i++) begin
         if (way_sel[i]) way = salc_pkg::WAY_W'(i);
      end
      way_rank = row_cur.rank[way];

      row_in = row_cur;
      if (!any_hit && any_free) begin
         for (int i = 0; i < salc_pkg::MAX_WAYS; i++) begin
            if (use_vec[i] && row_cur.valid[i] && row_cur.rank[i] < salc_pkg::RANK_MAX)
               row_in.rank[i] = row_cur.rank[i] + 1'b1;
         end
         row_in.valid[way] = 1'b1;
      end else begin
         for (int i = 0; i < salc_pkg::MAX_WAYS; i++) begin
            if (i != int'(way) && use_vec[i] && row_cur.valid[i] && row_cur.rank[i] < way_rank)
               row_in.rank[i] = row_cur.rank[i] + 1'b1;
         end
      end
      row_in.rank[way] = '0;
      if (!any_hit) row_in.tag[way] = s1_tag_ff;

      if (s1_op_ff == salc_pkg::OP_FETCH) outcome_in = salc_pkg::OUT_IGNORED;
      else if (any_hit)                   outcome_in = salc_pkg::OUT_HIT;
      else if (any_free)                  outcome_in = salc_pkg::OUT_FILL;
      else                                outcome_in = salc_pkg::OUT_EVICT;
      extra_in = (s1_op_ff == salc_pkg::OP_MODIFY);

      hit_in   = hit_ff + salc_pkg::CNT_W'(outcome_in == salc_pkg::OUT_HIT)
                        + salc_pkg::CNT_W'(extra_in);
      miss_in  = miss_ff + salc_pkg::CNT_W'((outcome_in == salc_pkg::OUT_FILL) ||
                                           (outcome_in == salc_pkg::OUT_EVICT));
      evict_in = evict_ff + salc_pkg::CNT_W'(outcome_in == salc_pkg::OUT_EVICT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= salc_pkg::SET_BITS_RST;
         block_bits_ff <= salc_pkg::BLOCK_BITS_RST;
         ways_ff       <= salc_pkg::WAYS_RST;
      end else if (csr_valid) begin
         case (csr_index)
            salc_pkg::CSR_SET_BITS:   set_bits_ff   <= csr_data[2:0];
            salc_pkg::CSR_BLOCK_BITS: block_bits_ff <= csr_data;
            salc_pkg::CSR_WAYS:       ways_ff       <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_ff       <= 1'b0;
         row_init_ff  <= '0;
         hit_ff       <= '0;
         miss_ff      <= '0;
         evict_ff     <= '0;
      end else begin
         if (advance) begin
            s1_valid_ff <= req_tvalid;
            fwd_ff      <= mem_wr && take && (set_in == s1_set_ff);
         end
         if (s1_valid_ff && advance) begin
            rsp_valid_ff <= 1'b1;
            hit_ff       <= hit_in;
            miss_ff      <= miss_in;
            evict_ff     <= evict_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (mem_wr) row_init_ff[s1_set_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_op_ff  <= req_tuser;
         s1_tag_ff <= tag_in;
         s1_set_ff <= set_in;
      end
      if (advance) fwd_row_ff <= row_in;
      if (s1_valid_ff && advance) begin
         rsp_outcome_ff <= outcome_in;
         rsp_extra_ff   <= extra_in;
      end
   end

   // line memory: one read port, one write port
   always_ff @(posedge clock) begin
      if (take) mem_q_ff <= line_mem_ff[set_in];
   end

   always_ff @(posedge clock) begin
      if (mem_wr) line_mem_ff[s1_set_ff] <= row_in;
   end

   `SALC_ASSERT_IMP(a_fetch_no_write, s1_valid_ff && s1_op_ff == salc_pkg::OP_FETCH,
      !mem_wr, "fetch item wrote the line memory")
   `SALC_ASSERT_IMP(a_victim_unique, s1_valid_ff && !any_hit && !any_free,
      $onehot(is_max), "victim choice is not unique")
   `SALC_ASSERT_NXT(a_miss_count, s1_valid_ff && advance &&
      (outcome_in == salc_pkg::OUT_FILL || outcome_in == salc_pkg::OUT_EVICT),
      miss_ff == $past(miss_ff) + 32'd1, "miss total did not advance on a miss")

endmodule

>>> verif/set_assoc_lru_cache_model_unit_check.sv
`timescale 1ns / 100ps
// Checker for set_assoc_lru_cache_model_unit: mirrors tags, valid bits and LRU ranks,
// predicts each result and compares it field by field. Depends on salc_pkg.
module set_assoc_lru_cache_model_unit_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // address [31:0]
   input  logic [1:0]  req_tuser,   // op [1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [95:0] rsp_tdata,   // hit_total [31:0], miss_total [63:32],
                                    // eviction_total [95:64]
   input  logic [2:0]  rsp_tuser,   // outcome [1:0], extra_hit [2]
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [4:0]  csr_data,
   output int          mismatch_count,
   output int          results_owed
);

   localparam int LINES = salc_pkg::SETS * salc_pkg::MAX_WAYS;

   typedef struct packed {
      logic [1:0]                 outcome;
      logic                       extra_hit;
      logic [salc_pkg::CNT_W-1:0] hit_total;
      logic [salc_pkg::CNT_W-1:0] miss_total;
      logic [salc_pkg::CNT_W-1:0] eviction_total;
   } access_result_type;

   logic [2:0]                  cfg_set_bits;
   logic [4:0]                  cfg_block_bits;
   logic [3:0]                  cfg_ways;
   bit                          line_valid [LINES];
   logic [salc_pkg::ADDR_W-1:0] line_tag [LINES];
   logic [salc_pkg::RANK_W-1:0] line_rank [LINES];
   logic [salc_pkg::CNT_W-1:0]  hits_seen;
   logic [salc_pkg::CNT_W-1:0]  misses_seen;
   logic [salc_pkg::CNT_W-1:0]  evictions_seen;
   access_result_type           owed_results [$];

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < 200) begin
         $display("%0t: %s mismatch: got %0h, expected %0h", $time, field, got, want);
      end
      mismatch_count++;
   endtask

   function automatic void promote_line(input int base, input int nw, input int w);
      logic [salc_pkg::RANK_W-1:0] r;
      r = line_rank[base + w];
      for (int i = 0; i < nw; i++) begin
         if (i != w && line_valid[base + i] && line_rank[base + i] < r) begin
            line_rank[base + i] = line_rank[base + i] + 1'b1;
         end
      end
      line_rank[base + w] = '0;
   endfunction

   function automatic logic [1:0] touch_line(input logic [salc_pkg::ADDR_W-1:0] addr);
      int                          sb;
      int                          nw;
      int                          base;
      int                          victim;
      logic [salc_pkg::ADDR_W-1:0] tag;
      logic [salc_pkg::ADDR_W-1:0] set_index;
      logic [salc_pkg::RANK_W-1:0] best;
      sb = (cfg_set_bits > salc_pkg::MAX_SET_BITS) ? salc_pkg::MAX_SET_BITS
                                                    : int'(cfg_set_bits);
      nw = (cfg_ways == 0) ? 1 :
           (cfg_ways > salc_pkg::MAX_WAYS) ? salc_pkg::MAX_WAYS : int'(cfg_ways);
      tag = addr >> (cfg_block_bits + sb);
      set_index = (addr >> cfg_block_bits) & ((32'd1 << sb) - 32'd1);
      base = int'(set_index) * salc_pkg::MAX_WAYS;
      for (int i = 0; i < nw; i++) begin
         if (line_valid[base + i] && line_tag[base + i] == tag) begin
            promote_line(base, nw, i);
            hits_seen++;
            return salc_pkg::OUT_HIT;
         end
      end
      misses_seen++;
      for (int i = 0; i < nw; i++) begin
         if (!line_valid[base + i]) begin
            for (int j = 0; j < nw; j++) begin
               if (line_valid[base + j] && line_rank[base + j] < salc_pkg::RANK_MAX) begin
                  line_rank[base + j] = line_rank[base + j] + 1'b1;
               end
            end
            line_valid[base + i] = 1'b1;
            line_tag[base + i] = tag;
            line_rank[base + i] = '0;
            return salc_pkg::OUT_FILL;
         end
      end
      victim = 0;
      best = line_rank[base];
      for (int i = 1; i < nw; i++) begin
         if (line_rank[base + i] > best) begin
            best = line_rank[base + i];
            victim = i;
         end
      end
      line_tag[base + victim] = tag;
      promote_line(base, nw, victim);
      evictions_seen++;
      return salc_pkg::OUT_EVICT;
   endfunction

   function automatic access_result_type predict_access(
      input logic [1:0] op, input logic [salc_pkg::ADDR_W-1:0] addr);
      access_result_type res;
      res.outcome = salc_pkg::OUT_IGNORED;
      res.extra_hit = 1'b0;
      if (op != salc_pkg::OP_FETCH) begin
         res.outcome = touch_line(addr);
         if (op == salc_pkg::OP_MODIFY) begin
            hits_seen++;
            res.extra_hit = 1'b1;
         end
      end
      res.hit_total = hits_seen;
      res.miss_total = misses_seen;
      res.eviction_total = evictions_seen;
      return res;
   endfunction

   always @(posedge clock) begin : watch
      access_result_type got;
      access_result_type want;
      if (reset) begin
         cfg_set_bits = salc_pkg::SET_BITS_RST;
         cfg_block_bits = salc_pkg::BLOCK_BITS_RST;
         cfg_ways = salc_pkg::WAYS_RST;
         for (int i = 0; i < LINES; i++) begin
            line_valid[i] = 1'b0;
            line_rank[i] = '0;
         end
         hits_seen = '0;
         misses_seen = '0;
         evictions_seen = '0;
         owed_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.outcome = rsp_tuser[1:0];
            got.extra_hit = rsp_tuser[2];
            got.hit_total = rsp_tdata[31:0];
            got.miss_total = rsp_tdata[63:32];
            got.eviction_total = rsp_tdata[95:64];
            if (owed_results.size() == 0) begin
               report_mismatch("unrequested item, hit_total", got.hit_total, '0);
            end else begin
               want = owed_results.pop_front();
               if (got.outcome !== want.outcome)
                  report_mismatch("outcome", got.outcome, want.outcome);
               if (got.extra_hit !== want.extra_hit)
                  report_mismatch("extra_hit", got.extra_hit, want.extra_hit);
               if (got.hit_total !== want.hit_total)
                  report_mismatch("hit_total", got.hit_total, want.hit_total);
               if (got.miss_total !== want.miss_total)
                  report_mismatch("miss_total", got.miss_total, want.miss_total);
               if (got.eviction_total !== want.eviction_total)
                  report_mismatch("eviction_total", got.eviction_total, want.eviction_total);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               salc_pkg::CSR_SET_BITS:   cfg_set_bits = csr_data[2:0];
               salc_pkg::CSR_BLOCK_BITS: cfg_block_bits = csr_data;
               salc_pkg::CSR_WAYS:       cfg_ways = csr_data[3:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            owed_results.push_back(predict_access(req_tuser, req_tdata));
         end
      end
      results_owed = owed_results.size();
   end

endmodule

>>> verif/set_assoc_lru_cache_model_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top for set_assoc_lru_cache_model_unit: drives cache accesses and geometry
// writes, stalls the result side, and reports the verdict from the checker.
// Depends on salc_pkg, the block and set_assoc_lru_cache_model_unit_check.
module set_assoc_lru_cache_model_unit_tb;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_STORE = 2'd1;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 55;
   localparam int POOL_SIZE     = 16;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // address [31:0]
   logic [1:0]  req_tuser = '0;   // op [1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;        // hit_total [31:0], miss_total [63:32],
                                  // eviction_total [95:64]
   logic [2:0]  rsp_tuser;        // outcome [1:0], extra_hit [2]
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [4:0]  csr_data = '0;

   int          mismatch_count;
   int          results_owed;
   int          burst_left = 0;
   logic [15:0] stall_pattern = '1;
   int          stall_phase = 0;

   always #5 clock = ~clock;

   set_assoc_lru_cache_model_unit i_dut (.*);

   set_assoc_lru_cache_model_unit_check i_access_check (.*);

   always @(posedge clock) begin
      if (stall_phase == 0) begin
         case ($urandom_range(0, 2))
            0: stall_pattern <= '1;
            1: stall_pattern <= 16'($urandom);
            default: stall_pattern <= 16'($urandom | $urandom);
         endcase
      end
      rsp_tready <= stall_pattern[stall_phase];
      stall_phase <= (stall_phase + 1) % 16;
   end

   task automatic send_access(input logic [1:0] op,
                              input logic [salc_pkg::ADDR_W-1:0] addr);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= addr;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (results_owed != 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic put_register(input logic [1:0] index, input logic [4:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_geometry(input logic [2:0] sb, input logic [4:0] bb, input logic [3:0] nw);
      wait_idle();
      put_register(salc_pkg::CSR_SET_BITS, {2'b00, sb});
      put_register(salc_pkg::CSR_BLOCK_BITS, bb);
      put_register(salc_pkg::CSR_WAYS, {1'b0, nw});
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [salc_pkg::ADDR_W-1:0] address_pool [POOL_SIZE];
      logic [salc_pkg::ADDR_W-1:0] shared_low;
      logic [salc_pkg::ADDR_W-1:0] addr;
      logic [1:0]                  op;
      int                          pool_used;
      bit                          same_set;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset geometry: direct mapped, 16 sets of 16-byte blocks
      send_access(salc_pkg::OP_FETCH, 32'h0000_0000);
      send_access(OP_LOAD, 32'h0000_0000);
      send_access(OP_STORE, 32'h0000_000c);
      send_access(salc_pkg::OP_MODIFY, 32'h0000_0100);
      send_access(OP_LOAD, 32'hffff_ffff);
      send_access(salc_pkg::OP_MODIFY, 32'hffff_fff0);
      send_access(salc_pkg::OP_FETCH, 32'hffff_ffff);

      // one set, byte blocks, four ways: fill, refresh, then evict the oldest
      set_geometry(3'd0, 5'd0, 4'd4);
      send_access(OP_LOAD, 32'd1);
      send_access(OP_LOAD, 32'd2);
      send_access(OP_STORE, 32'd3);
      send_access(OP_LOAD, 32'd4);
      send_access(OP_LOAD, 32'd1);
      send_access(OP_LOAD, 32'd5);
      send_access(salc_pkg::OP_MODIFY, 32'd2);
      send_access(OP_STORE, 32'd1);

      // oversized fields: saturated set bits and ways, tag shifted out entirely
      set_geometry(3'd7, 5'd31, 4'd15);
      send_access(OP_LOAD, 32'h8000_0000);
      send_access(OP_LOAD, 32'hffff_ffff);
      send_access(OP_LOAD, 32'h0000_0000);
      send_access(salc_pkg::OP_MODIFY, 32'h7fff_ffff);

      // zero ways behaves as one
      set_geometry(3'd6, 5'd26, 4'd0);
      send_access(OP_LOAD, 32'h0000_0000);
      send_access(OP_LOAD, 32'hffff_ffff);
      send_access(OP_STORE, 32'h0400_0000);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_geometry(3'($urandom_range(0, 7)),
                      ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                                   : 5'($urandom_range(0, 6)),
                      4'($urandom_range(0, 15)));
         pool_used = $urandom_range(2, POOL_SIZE);
         same_set = $urandom_range(0, 1);
         shared_low = $urandom & 32'h0000_0fff;
         foreach (address_pool[i]) begin
            address_pool[i] = same_set ? (($urandom & 32'hffff_f000) | shared_low) : $urandom;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            case ($urandom_range(0, 9))
               0, 1, 2: op = OP_LOAD;
               3, 4, 5: op = OP_STORE;
               6, 7, 8: op = salc_pkg::OP_MODIFY;
               default: op = salc_pkg::OP_FETCH;
            endcase
            if ($urandom_range(0, 4) == 0) begin
               addr = $urandom;
            end else begin
               addr = address_pool[$urandom_range(0, pool_used - 1)] ^ 32'($urandom_range(0, 3));
            end
            send_access(op, addr);
         end
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("simulation failed");
      $finish;
   end

endmodule
